// ===== sv/rdlp_pkg.sv =====
// Shared constants and types of the random delta line prefetcher.
package rdlp_pkg;

    // Sizes of the storage and of the loops.
    localparam int TRACKER_DEPTH = 64;
    localparam int NUM_DELTAS    = 4;
    localparam int MAX_DEGREE    = 8;
    localparam int QUEUE_DEPTH   = 2;

    // Address geometry: 64-byte blocks, 4096-byte pages.
    localparam int ADDR_W      = 64;
    localparam int DRAW_W      = 16;
    localparam int BLOCK_SHIFT = 6;
    localparam int PAGE_SHIFT  = 12;
    localparam int OFFSET_W    = PAGE_SHIFT - BLOCK_SHIFT;
    localparam int BASE_W      = ADDR_W - PAGE_SHIFT;
    localparam int LINE_W      = ADDR_W - BLOCK_SHIFT;

    // Field widths.
    localparam int DELTA_W    = 8;
    localparam int THR_W      = 16;
    localparam int DIDX_W     = 2;
    localparam int DEG_CFG_W  = 4;
    localparam int SIZE_CFG_W = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Derived widths.
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int CAND_W =
        $clog2(MAX_DEGREE * (1 << (DELTA_W - 1)) + (1 << OFFSET_W)) + 1;
    localparam int TIDX_W = (TRACKER_DEPTH > 1) ? $clog2(TRACKER_DEPTH) : 1;
    localparam int TCNT_W = $clog2(TRACKER_DEPTH + 1);
    localparam int TREL_W = TCNT_W + 1;
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_TABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_TABLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACKING_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRACKER_SIZE    = 3'd4;

    // Configuration seen by the front and back ends.
    typedef struct packed {
        logic [NUM_DELTAS*DELTA_W-1:0] delta_table;
        logic [NUM_DELTAS*THR_W-1:0]   prob_table;
        logic [DEG_CFG_W-1:0]          degree;
        logic                          tracking_enable;
        logic [SIZE_CFG_W-1:0]         tracker_size;
    } cfg_t;

    // One classified access, as queued between the front and back ends.
    typedef struct packed {
        logic [BASE_W-1:0]          page_base;
        logic [OFFSET_W-1:0]        offset;
        logic signed [DELTA_W-1:0]  delta;
        logic [DIDX_W-1:0]          sel_index;
        logic [DEG_W-1:0]           degree;
    } cmd_t;

endpackage

// ===== sv/rdlp_front.sv =====
// Front end: accepts demand accesses, picks the delta and queues a command.
module rdlp_front (
    input  rdlp_pkg::cfg_t                    cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rdlp_pkg::ADDR_W-1:0]       s_access_address,
    input  logic [rdlp_pkg::DRAW_W-1:0]       s_rand_draw,
    input  logic                              q_full,
    output logic                              q_push,
    output rdlp_pkg::cmd_t                    q_cmd
);

    logic [rdlp_pkg::DIDX_W-1:0] sel;
    logic [rdlp_pkg::DEG_W-1:0]  deg_sat;

    // The first threshold that reaches the draw wins; entry 0 when none does.
    always_comb begin
        sel = '0;
        for (int i = rdlp_pkg::NUM_DELTAS - 1; i >= 0; i--) begin
            if (s_rand_draw <= cfg.prob_table[i*rdlp_pkg::THR_W +: rdlp_pkg::THR_W]) begin
                sel = rdlp_pkg::DIDX_W'(i);
            end
        end
    end

    // Degree above the supported maximum is saturated.
    always_comb begin
        if (32'(cfg.degree) > rdlp_pkg::MAX_DEGREE) begin
            deg_sat = rdlp_pkg::DEG_W'(rdlp_pkg::MAX_DEGREE);
        end else begin
            deg_sat = rdlp_pkg::DEG_W'(cfg.degree);
        end
    end

    // Build the command for the back end.
    always_comb begin
        q_cmd.page_base = s_access_address[rdlp_pkg::ADDR_W-1:rdlp_pkg::PAGE_SHIFT];
        q_cmd.offset    = s_access_address[rdlp_pkg::PAGE_SHIFT-1:rdlp_pkg::BLOCK_SHIFT];
        q_cmd.delta     = cfg.delta_table[32'(sel)*rdlp_pkg::DELTA_W +: rdlp_pkg::DELTA_W];
        q_cmd.sel_index = sel;
        q_cmd.degree    = deg_sat;
    end

    // An access with degree zero produces no results and is simply consumed.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && (deg_sat != '0);

endmodule

// ===== sv/rdlp_queue.sv =====
// Small command queue between the front and back ends.
module rdlp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rdlp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output rdlp_pkg::cmd_t pop_cmd,
    output logic           empty
);

    rdlp_pkg::cmd_t                entries_reg [rdlp_pkg::QUEUE_DEPTH];
    logic [rdlp_pkg::QIDX_W-1:0]   wr_ptr_reg;
    logic [rdlp_pkg::QIDX_W-1:0]   wr_ptr_next;
    logic [rdlp_pkg::QIDX_W-1:0]   rd_ptr_reg;
    logic [rdlp_pkg::QIDX_W-1:0]   rd_ptr_next;
    logic [rdlp_pkg::QCNT_W-1:0]   count_reg;
    logic [rdlp_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == rdlp_pkg::QCNT_W'(rdlp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entries_reg[rd_ptr_reg];

    // Pointer and occupancy updates with wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == rdlp_pkg::QIDX_W'(rdlp_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == rdlp_pkg::QIDX_W'(rdlp_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/rdlp_back.sv =====
// Back end: steps through the degree, filters through the tracker, emits results.
module rdlp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rdlp_pkg::cfg_t                cfg,
    input  logic                          q_empty,
    input  rdlp_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rdlp_pkg::ADDR_W-1:0]   m_prefetch_address,
    output logic                          m_issued,
    output logic [rdlp_pkg::DIDX_W-1:0]   m_delta_index,
    output logic                          m_last
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;

    // Current access.
    logic [rdlp_pkg::BASE_W-1:0]             base_reg;
    logic signed [rdlp_pkg::DELTA_W-1:0]     delta_reg;
    logic [rdlp_pkg::DIDX_W-1:0]             didx_reg;
    logic [rdlp_pkg::DEG_W-1:0]              deg_reg;
    logic [rdlp_pkg::DEG_W-1:0]              step_reg;
    logic signed [rdlp_pkg::CAND_W-1:0]      cand_reg;

    // Tracker ring and its registered match vector.
    logic [rdlp_pkg::LINE_W-1:0]             lines_reg [rdlp_pkg::TRACKER_DEPTH];
    logic [rdlp_pkg::TCNT_W-1:0]             count_reg;
    logic [rdlp_pkg::TIDX_W-1:0]             oldest_reg;
    logic [rdlp_pkg::TRACKER_DEPTH-1:0]      hit_reg;
    logic [rdlp_pkg::TRACKER_DEPTH-1:0]      hit_next;

    // Output register.
    logic                                    m_valid_reg;
    logic [rdlp_pkg::ADDR_W-1:0]             addr_reg;
    logic                                    issued_reg;
    logic [rdlp_pkg::DIDX_W-1:0]             didx_out_reg;
    logic                                    last_reg;

    logic [rdlp_pkg::LINE_W-1:0]             line;
    logic                                    in_page;
    logic                                    out_free;
    logic                                    emit;
    logic                                    issue;
    logic                                    do_insert;
    logic                                    final_step;
    logic [rdlp_pkg::TCNT_W-1:0]             lim;
    logic                                    tracker_full;
    logic [rdlp_pkg::TREL_W-1:0]             tail_sum;
    logic [rdlp_pkg::TIDX_W-1:0]             tail_idx;
    logic [rdlp_pkg::TIDX_W-1:0]             wr_idx;

    // Candidate line and page check.
    assign line       = {base_reg, cand_reg[rdlp_pkg::OFFSET_W-1:0]};
    assign in_page    = (cand_reg[rdlp_pkg::CAND_W-1:rdlp_pkg::OFFSET_W] == '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = (state_reg == ST_EMIT) && out_free;
    assign final_step = (step_reg == deg_reg);
    assign issue      = in_page && (!cfg.tracking_enable || (hit_reg == '0));
    assign do_insert  = emit && cfg.tracking_enable && in_page && (hit_reg == '0);
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;

    // Compare the candidate against every live tracker entry in parallel.
    always_comb begin
        logic [rdlp_pkg::TREL_W-1:0] rel;
        for (int i = 0; i < rdlp_pkg::TRACKER_DEPTH; i++) begin
            if (rdlp_pkg::TIDX_W'(i) >= oldest_reg) begin
                rel = rdlp_pkg::TREL_W'(i) - rdlp_pkg::TREL_W'(oldest_reg);
            end else begin
                rel = rdlp_pkg::TREL_W'(i + rdlp_pkg::TRACKER_DEPTH)
                      - rdlp_pkg::TREL_W'(oldest_reg);
            end
            hit_next[i] = (rel < rdlp_pkg::TREL_W'(count_reg)) && (lines_reg[i] == line);
        end
    end

    // Entries in use, clamped to between one and the tracker depth.
    always_comb begin
        if (cfg.tracker_size == '0) begin
            lim = rdlp_pkg::TCNT_W'(1);
        end else if (32'(cfg.tracker_size) > rdlp_pkg::TRACKER_DEPTH) begin
            lim = rdlp_pkg::TCNT_W'(rdlp_pkg::TRACKER_DEPTH);
        end else begin
            lim = rdlp_pkg::TCNT_W'(cfg.tracker_size);
        end
    end

    // Insert position: after the newest entry, or over the oldest when full.
    always_comb begin
        tracker_full = (count_reg >= lim);
        tail_sum     = rdlp_pkg::TREL_W'(oldest_reg) + rdlp_pkg::TREL_W'(count_reg);
        if (tail_sum >= rdlp_pkg::TREL_W'(rdlp_pkg::TRACKER_DEPTH)) begin
            tail_sum = tail_sum - rdlp_pkg::TREL_W'(rdlp_pkg::TRACKER_DEPTH);
        end
        tail_idx = rdlp_pkg::TIDX_W'(tail_sum);
        wr_idx   = tracker_full ? oldest_reg : tail_idx;
    end

    // Sequencer: load a command, then a lookup state and an emit state per step.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = final_step ? ST_IDLE : ST_LOOKUP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_insert) begin
                if (tracker_full) begin
                    if (oldest_reg == rdlp_pkg::TIDX_W'(rdlp_pkg::TRACKER_DEPTH - 1)) begin
                        oldest_reg <= '0;
                    end else begin
                        oldest_reg <= oldest_reg + 1'b1;
                    end
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers of the current access and step.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            base_reg  <= q_cmd.page_base;
            delta_reg <= q_cmd.delta;
            didx_reg  <= q_cmd.sel_index;
            deg_reg   <= q_cmd.degree;
            step_reg  <= rdlp_pkg::DEG_W'(1);
            cand_reg  <= $signed(rdlp_pkg::CAND_W'(q_cmd.offset))
                         + rdlp_pkg::CAND_W'($signed(q_cmd.delta));
        end else if (emit && !final_step) begin
            step_reg <= step_reg + 1'b1;
            cand_reg <= cand_reg + rdlp_pkg::CAND_W'(delta_reg);
        end
        if (state_reg == ST_LOOKUP) begin
            hit_reg <= hit_next;
        end
    end

    // Tracker line storage has no reset; only live entries are compared.
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            lines_reg[wr_idx] <= line;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (emit) begin
            addr_reg     <= issue ? {line, rdlp_pkg::BLOCK_SHIFT'(0)} : '0;
            issued_reg   <= issue;
            didx_out_reg <= didx_reg;
            last_reg     <= final_step;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_prefetch_address = addr_reg;
    assign m_issued           = issued_reg;
    assign m_delta_index      = didx_out_reg;
    assign m_last             = last_reg;

endmodule

// ===== sv/random_delta_line_prefetcher.sv =====
// Random delta line prefetcher: each demand access picks one of four block
// deltas from a random draw and a table of cumulative thresholds, then forms
// one candidate per degree step, issued only inside the 4096-byte page and
// optionally suppressed when already present in a FIFO tracker of recent
// prefetches. One result per degree step comes out, with last on the final
// one; an access with degree zero gives no result. The front end places each
// access in a two-entry command queue while it is not full, so new accesses
// are taken while earlier ones are still being worked on. The back end loads
// a command, then per degree step runs a lookup state (a parallel compare
// against all tracker entries into a registered match vector) and an emit
// state (decision, tracker insert and result register, held while the output
// is stalled); the tracker compare is why the lookup has its own state.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
module random_delta_line_prefetcher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdlp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rdlp_pkg::ADDR_W-1:0]         s_access_address,
    input  logic [rdlp_pkg::DRAW_W-1:0]         s_rand_draw,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rdlp_pkg::ADDR_W-1:0]         m_prefetch_address,
    output logic                                m_issued,
    output logic [rdlp_pkg::DIDX_W-1:0]         m_delta_index,
    output logic                                m_last
);

    rdlp_pkg::cfg_t cfg_reg;
    rdlp_pkg::cmd_t push_cmd;
    rdlp_pkg::cmd_t pop_cmd;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delta_table     <= (rdlp_pkg::NUM_DELTAS*rdlp_pkg::DELTA_W)'(1);
            cfg_reg.prob_table      <= '1;
            cfg_reg.degree          <= rdlp_pkg::DEG_CFG_W'(1);
            cfg_reg.tracking_enable <= 1'b0;
            cfg_reg.tracker_size    <= rdlp_pkg::SIZE_CFG_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                rdlp_pkg::REG_DELTA_TABLE: begin
                    cfg_reg.delta_table <=
                        cfg_data[rdlp_pkg::NUM_DELTAS*rdlp_pkg::DELTA_W-1:0];
                end
                rdlp_pkg::REG_PROB_TABLE: begin
                    cfg_reg.prob_table <=
                        cfg_data[rdlp_pkg::NUM_DELTAS*rdlp_pkg::THR_W-1:0];
                end
                rdlp_pkg::REG_DEGREE: begin
                    cfg_reg.degree <= cfg_data[rdlp_pkg::DEG_CFG_W-1:0];
                end
                rdlp_pkg::REG_TRACKING_ENABLE: begin
                    cfg_reg.tracking_enable <= cfg_data[0];
                end
                rdlp_pkg::REG_TRACKER_SIZE: begin
                    cfg_reg.tracker_size <= cfg_data[rdlp_pkg::SIZE_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rdlp_front u_front (
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_access_address (s_access_address),
        .s_rand_draw      (s_rand_draw),
        .q_full           (q_full),
        .q_push           (push),
        .q_cmd            (push_cmd)
    );

    rdlp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    rdlp_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_empty            (q_empty),
        .q_cmd              (pop_cmd),
        .q_pop              (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prefetch_address (m_prefetch_address),
        .m_issued           (m_issued),
        .m_delta_index      (m_delta_index),
        .m_last             (m_last)
    );

endmodule
